/* rtl/ftbt_pkg.sv */
// Shared widths, codes and record types of the firmware transfer block tracker.
// Used by the channel interfaces and by every tracker module.
package ftbt_pkg;

  localparam int CMD_W   = 2;
  localparam int BLK_W   = 16;
  localparam int LEN_W   = 13;
  localparam int ST_W    = 2;
  localparam int CNT_W   = 13;
  localparam int COFF_W  = 15;
  localparam int FIRST_W = 13;
  localparam int MEM_W   = 24;
  localparam int FLEN_W  = 15;
  localparam int SESS_W  = 2;

  localparam int BLOCK_BYTES  = 16384;
  localparam int MAX_TRANSFER = 4096;
  localparam int BUF_W        = $clog2(BLOCK_BYTES);
  localparam int FILL_W       = BUF_W + 1;

  localparam logic [MEM_W-1:0] MEM_RESET = MEM_W'(8388608);

  localparam logic [CMD_W-1:0] CMD_DOWNLOAD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_UPLOAD   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MANIFEST = 2'd2;
  localparam logic [CMD_W-1:0] CMD_ABORT    = 2'd3;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_ADDR_ERR  = 2'd1;
  localparam logic [ST_W-1:0] ST_UNKNOWN   = 2'd2;
  localparam logic [ST_W-1:0] ST_NO_STATUS = 2'd3;

  localparam logic [SESS_W-1:0] SESS_NONE = 2'd0;
  localparam logic [SESS_W-1:0] SESS_UP   = 2'd1;
  localparam logic [SESS_W-1:0] SESS_DOWN = 2'd2;

  typedef struct packed {
    logic [SESS_W-1:0] sess;
    logic [MEM_W-1:0]  offset;
    logic [BUF_W-1:0]  buffered;
  } track_t;

  typedef struct packed {
    logic [ST_W-1:0]    status;
    logic [CNT_W-1:0]   upload_count;
    logic [COFF_W-1:0]  copy_offset;
    logic [FIRST_W-1:0] first_part_bytes;
    logic               flush_valid;
    logic [MEM_W-1:0]   flush_offset;
    logic [FLEN_W-1:0]  flush_length;
  } result_t;

endpackage

/* rtl/ftbt_in_if.sv */
// Request channel of the tracker: valid/ready handshake with the item fields.
// Depends on ftbt_pkg for field widths.
interface ftbt_in_if;
  import ftbt_pkg::*;

  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [BLK_W-1:0] block_number;
  logic [LEN_W-1:0] length;

  modport source (output valid, cmd, block_number, length, input ready);
  modport sink   (input valid, cmd, block_number, length, output ready);
endinterface

/* rtl/ftbt_out_if.sv */
// Result channel of the tracker: valid/ready handshake with the result fields.
// Depends on ftbt_pkg for field widths.
interface ftbt_out_if;
  import ftbt_pkg::*;

  logic               valid;
  logic               ready;
  logic [ST_W-1:0]    status;
  logic [CNT_W-1:0]   upload_count;
  logic [COFF_W-1:0]  copy_offset;
  logic [FIRST_W-1:0] first_part_bytes;
  logic               flush_valid;
  logic [MEM_W-1:0]   flush_offset;
  logic [FLEN_W-1:0]  flush_length;

  modport source (output valid, status, upload_count, copy_offset, first_part_bytes,
                  flush_valid, flush_offset, flush_length, input ready);
  modport sink   (input valid, status, upload_count, copy_offset, first_part_bytes,
                  flush_valid, flush_offset, flush_length, output ready);
endinterface

/* rtl/ftbt_step.sv */
// Next-state and result logic for one transaction of the tracker.
// Depends on ftbt_pkg for codes and record types.
module ftbt_step (
  input  logic [ftbt_pkg::CMD_W-1:0] cmd_i,
  input  logic [ftbt_pkg::BLK_W-1:0] block_number_i,
  input  logic [ftbt_pkg::LEN_W-1:0] length_i,
  input  logic [ftbt_pkg::MEM_W-1:0] memory_bytes_i,
  input  ftbt_pkg::track_t           cur_i,
  output ftbt_pkg::track_t           nxt_o,
  output ftbt_pkg::result_t          res_o
);
  import ftbt_pkg::*;

  logic              len_bad;
  logic              opening;
  logic              refuse;
  logic [MEM_W-1:0]  eff_off;
  logic [BUF_W-1:0]  eff_buf;
  logic [MEM_W:0]    up_sum;
  logic              up_end;
  logic [MEM_W-1:0]  up_left;
  logic [LEN_W-1:0]  up_todo;
  logic [MEM_W:0]    used;
  logic [MEM_W+1:0]  dn_sum;
  logic              dn_reach;
  logic              dn_over;
  logic [MEM_W:0]    dn_left;
  logic [LEN_W-1:0]  dn_len;
  logic [FILL_W-1:0] fill;
  logic              dn_split;
  logic [FILL_W-1:0] room;
  logic [LEN_W-1:0]  rest;

  assign len_bad = length_i[0] || (length_i > LEN_W'(MAX_TRANSFER));
  assign opening = (cmd_i == CMD_UPLOAD) ? (cur_i.sess != SESS_UP) : (cur_i.sess != SESS_DOWN);
  assign refuse  = opening && ((block_number_i != '0) || (cur_i.sess != SESS_NONE));
  assign eff_off = opening ? '0 : cur_i.offset;
  assign eff_buf = opening ? '0 : cur_i.buffered;

  assign up_sum  = (MEM_W+1)'(eff_off) + (MEM_W+1)'(length_i);
  assign up_end  = up_sum >= (MEM_W+1)'(memory_bytes_i);
  assign up_left = (eff_off < memory_bytes_i) ? (memory_bytes_i - eff_off) : '0;
  assign up_todo = up_end ? LEN_W'(up_left) : length_i;

  assign used     = (MEM_W+1)'(eff_off) + (MEM_W+1)'(eff_buf);
  assign dn_sum   = (MEM_W+2)'(used) + (MEM_W+2)'(length_i);
  assign dn_reach = dn_sum >= (MEM_W+2)'(memory_bytes_i);
  assign dn_over  = used > (MEM_W+1)'(memory_bytes_i);
  assign dn_left  = (MEM_W+1)'(memory_bytes_i) - used;
  assign dn_len   = dn_reach ? LEN_W'(dn_left) : length_i;

  assign fill     = FILL_W'(eff_buf) + FILL_W'(dn_len);
  assign dn_split = fill >= FILL_W'(BLOCK_BYTES);
  assign room     = FILL_W'(BLOCK_BYTES) - FILL_W'(eff_buf);
  assign rest     = dn_len - LEN_W'(room);

  always_comb begin
    nxt_o = cur_i;
    res_o = '0;
    case (cmd_i)
      CMD_ABORT: begin
        nxt_o.sess   = SESS_NONE;
        res_o.status = ST_NO_STATUS;
      end
      CMD_MANIFEST: begin
        if (cur_i.sess != SESS_DOWN) begin
          res_o.status = ST_UNKNOWN;
        end else begin
          if (cur_i.buffered != '0) begin
            res_o.flush_valid  = 1'b1;
            res_o.flush_offset = cur_i.offset;
            res_o.flush_length = FLEN_W'(cur_i.buffered);
            nxt_o.offset       = cur_i.offset + MEM_W'(cur_i.buffered);
            nxt_o.buffered     = '0;
          end
          nxt_o.sess   = SESS_NONE;
          res_o.status = ST_OK;
        end
      end
      CMD_UPLOAD: begin
        if (len_bad) begin
          res_o.status = ST_ADDR_ERR;
        end else if (refuse) begin
          res_o.status = ST_UNKNOWN;
        end else begin
          nxt_o.offset       = eff_off + MEM_W'(up_todo);
          nxt_o.buffered     = eff_buf;
          nxt_o.sess         = up_end ? SESS_NONE : SESS_UP;
          res_o.status       = ST_NO_STATUS;
          res_o.upload_count = CNT_W'(up_todo);
        end
      end
      default: begin
        if (len_bad) begin
          res_o.status = ST_ADDR_ERR;
        end else if (refuse) begin
          res_o.status = ST_UNKNOWN;
        end else if (dn_reach && dn_over) begin
          res_o.status = ST_ADDR_ERR;
        end else begin
          nxt_o.sess        = SESS_DOWN;
          res_o.status      = ST_OK;
          res_o.copy_offset = COFF_W'(eff_buf);
          if (dn_split) begin
            nxt_o.offset           = eff_off + MEM_W'(BLOCK_BYTES);
            nxt_o.buffered         = BUF_W'(rest);
            res_o.first_part_bytes = FIRST_W'(room);
            res_o.flush_valid      = 1'b1;
            res_o.flush_offset     = eff_off;
            res_o.flush_length     = FLEN_W'(BLOCK_BYTES);
          end else begin
            nxt_o.offset           = eff_off;
            nxt_o.buffered         = BUF_W'(fill);
            res_o.first_part_bytes = FIRST_W'(dn_len);
          end
        end
      end
    endcase
  end

endmodule

/* rtl/ftbt_skid.sv */
// Two-entry result buffer: output register plus skid register.
// Depends on ftbt_pkg for the result record.
module ftbt_skid (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  input  ftbt_pkg::result_t push_data_i,
  output logic              push_ready_o,
  output logic              pop_valid_o,
  output ftbt_pkg::result_t pop_data_o,
  input  logic              pop_ready_i
);
  import ftbt_pkg::*;

  logic    main_valid_q;
  logic    skid_valid_q;
  result_t main_data_q;
  result_t skid_data_q;
  logic    push;
  logic    load_main;

  assign push_ready_o = !skid_valid_q;
  assign push         = push_valid_i && !skid_valid_q;
  assign load_main    = pop_ready_i || !main_valid_q;
  assign pop_valid_o  = main_valid_q;
  assign pop_data_o   = main_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (load_main) begin
      main_valid_q <= skid_valid_q || push;
      skid_valid_q <= 1'b0;
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_main) begin
      main_data_q <= skid_valid_q ? skid_data_q : push_data_i;
    end else if (push) begin
      skid_data_q <= push_data_i;
    end
  end

endmodule

/* rtl/firmware_transfer_block_tracker.sv */
// Top level of the firmware transfer block tracker: APB register, session state, result buffer.
// Depends on ftbt_pkg, ftbt_in_if, ftbt_out_if, ftbt_step and ftbt_skid.
//
// The tracker takes one transaction per clock cycle while the result buffer has room and returns
// one result per transaction, in order, from the buffer's output register. All decisions for a
// transaction are made combinationally from the session registers; the results pass through a
// two-entry buffer, so the request side stalls only when two results wait unread. memory_bytes
// sits at byte address 0 and may be written only while no transaction is outstanding.
module firmware_transfer_block_tracker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  ftbt_in_if.sink           in_i,
  ftbt_out_if.source        out_o
);
  import ftbt_pkg::*;

  logic [MEM_W-1:0] mem_q;
  track_t           track_q;
  track_t           track_d;
  result_t          res;
  result_t          out_data;
  logic             accept;
  logic             cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && !paddr[2];
  assign prdata    = paddr[2] ? '0 : 32'(mem_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_q <= MEM_RESET;
    end else if (cfg_write) begin
      mem_q <= pwdata[MEM_W-1:0];
    end
  end

  ftbt_step u_step (
    .cmd_i          (in_i.cmd),
    .block_number_i (in_i.block_number),
    .length_i       (in_i.length),
    .memory_bytes_i (mem_q),
    .cur_i          (track_q),
    .nxt_o          (track_d),
    .res_o          (res)
  );

  assign accept = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      track_q <= '{sess: SESS_NONE, offset: '0, buffered: '0};
    end else if (accept) begin
      track_q <= track_d;
    end
  end

  ftbt_skid u_skid (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_i.valid),
    .push_data_i  (res),
    .push_ready_o (in_i.ready),
    .pop_valid_o  (out_o.valid),
    .pop_data_o   (out_data),
    .pop_ready_i  (out_o.ready)
  );

  assign out_o.status           = out_data.status;
  assign out_o.upload_count     = out_data.upload_count;
  assign out_o.copy_offset      = out_data.copy_offset;
  assign out_o.first_part_bytes = out_data.first_part_bytes;
  assign out_o.flush_valid      = out_data.flush_valid;
  assign out_o.flush_offset     = out_data.flush_offset;
  assign out_o.flush_length     = out_data.flush_length;

endmodule
